[hdl/tbs_pkg.sv]
`timescale 1ns / 1ps

package tbs_pkg;

    // Sizes of the statistics tables.
    localparam int LAYER_SLOTS    = 16;
    localparam int MAX_THRESHOLDS = 7;
    localparam int NUM_BUCKETS    = MAX_THRESHOLDS - 1;
    localparam int NUM_ENTRIES    = NUM_BUCKETS * LAYER_SLOTS;

    // Field and index widths.
    localparam int SLOT_W     = 4;
    localparam int BUCKET_W   = 3;
    localparam int ENTRY_W    = $clog2(NUM_ENTRIES);
    localparam int CNT_W      = 32;
    localparam int VAL_W      = 32;
    localparam int KEY_W      = 2 * VAL_W;
    localparam int TIU_W      = 3;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLDS_IN_USE = 3'd7;

    // Command codes of an input item.
    typedef enum logic {
        CMD_RECORD = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    // One input item.
    typedef struct packed {
        cmd_t                cmd;
        logic [SLOT_W-1:0]   layer_slot;
        logic                layer_is_one;
        logic [VAL_W-1:0]    vertex_count;
        logic [VAL_W-1:0]    edge_count;
        logic [BUCKET_W-1:0] bucket_sel;
    } req_t;

    // One result item.
    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic                out_of_range;
        logic [CNT_W-1:0]    record_number;
        logic [CNT_W-1:0]    entry_count;
        logic [VAL_W-1:0]    min_edges;
        logic [VAL_W-1:0]    min_vertices;
        logic [VAL_W-1:0]    max_edges;
        logic [VAL_W-1:0]    max_vertices;
        logic [CNT_W-1:0]    bucket_total;
        logic [CNT_W-1:0]    bucket_layer_one_total;
    } rsp_t;

    // One row of the per-(bucket, slot) table; keys are {edges, vertices}.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [KEY_W-1:0] min_key;
        logic [KEY_W-1:0] max_key;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic classify;
        logic lookup;
        logic compare;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip_lookup;
    } dp_status_t;

    // Counter increment that sticks at all ones.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        sat_inc = (x == {CNT_W{1'b1}}) ? x : x + 1'b1;
    endfunction

endpackage

[hdl/tbs_ctrl.sv]
`timescale 1ns / 1ps

module tbs_ctrl
    import tbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t status,
    output dp_cmd_t    dp_cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_CLASSIFY = 6'b000010,
        S_LOOKUP   = 6'b000100,
        S_COMPARE  = 6'b001000,
        S_FINISH   = 6'b010000,
        S_OUTPUT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence of one item through the datapath.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                state_next = status.skip_lookup ? S_FINISH : S_LOOKUP;
            end
            S_LOOKUP:
            begin
                state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_OUTPUT;
            end
            S_OUTPUT:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Handshake and datapath commands follow the state.
    assign req_ready       = (state_reg == S_IDLE);
    assign rsp_valid       = (state_reg == S_OUTPUT);
    assign dp_cmd.load     = (state_reg == S_IDLE) && req_valid;
    assign dp_cmd.classify = (state_reg == S_CLASSIFY);
    assign dp_cmd.lookup   = (state_reg == S_LOOKUP);
    assign dp_cmd.compare  = (state_reg == S_COMPARE);
    assign dp_cmd.finish   = (state_reg == S_FINISH);

endmodule

[hdl/tbs_datapath.sv]
`timescale 1ns / 1ps

module tbs_datapath
    import tbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  req_t                  req,
    input  dp_cmd_t               dp_cmd,
    output dp_status_t            status,
    output rsp_t                  rsp
);

    localparam entry_t ENTRY_EMPTY = '{count: '0, min_key: '1, max_key: '0};

    // Configuration registers.
    logic [VAL_W-1:0] thresholds_reg [MAX_THRESHOLDS];
    logic [TIU_W-1:0] tiu_reg;

    // Captured item and its classification.
    req_t                req_reg;
    logic [BUCKET_W-1:0] bucket_reg;
    logic [BUCKET_W-1:0] bucket_next;
    logic                oor_reg;
    logic                oor_next;
    logic [ENTRY_W-1:0]  idx_reg;
    logic [ENTRY_W-1:0]  idx_next;

    // Statistics storage.
    entry_t               entry_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]     total_reg [NUM_BUCKETS];
    logic [CNT_W-1:0]     lone_reg [NUM_BUCKETS];
    logic [CNT_W-1:0]     record_reg;

    // Lookup and compare results.
    entry_t           rdata_reg;
    logic             rvalid_reg;
    logic [CNT_W-1:0] total_rd_reg;
    logic [CNT_W-1:0] lone_rd_reg;
    logic             lt_min_reg;
    logic             gt_max_reg;

    // Finishing step.
    entry_t           entry_eff;
    entry_t           entry_next;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] total_next;
    logic [CNT_W-1:0] lone_next;
    logic             update;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic [MAX_THRESHOLDS-1:0] below;
    logic [BUCKET_W-1:0]       first;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THRESHOLDS; i++)
            begin
                thresholds_reg[i] <= '0;
            end
            tiu_reg <= TIU_W'(2);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_THRESHOLDS_IN_USE)
            begin
                tiu_reg <= cfg_data[TIU_W-1:0];
            end
            else
            begin
                thresholds_reg[cfg_index] <= cfg_data[VAL_W-1:0];
            end
        end
    end

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            req_reg <= req;
        end
    end

    // Parallel threshold compares and first-match search.
    always_comb
    begin
        for (int i = 0; i < MAX_THRESHOLDS; i++)
        begin
            below[i] = (req_reg.edge_count < thresholds_reg[i]) &&
                       (TIU_W'(i) < tiu_reg);
        end
        first = '0;
        for (int i = MAX_THRESHOLDS - 1; i >= 0; i--)
        begin
            if (below[i])
            begin
                first = BUCKET_W'(i);
            end
        end
    end

    // Bucket, table index and range flag of the item.
    always_comb
    begin
        if (req_reg.cmd == CMD_RECORD)
        begin
            bucket_next = first - 1'b1;
            oor_next    = !(|below) || (first == '0);
        end
        else
        begin
            bucket_next = req_reg.bucket_sel;
            oor_next    = (int'(req_reg.bucket_sel) >= NUM_BUCKETS);
        end
        idx_next = ENTRY_W'(int'(bucket_next) * LAYER_SLOTS + int'(req_reg.layer_slot));
    end

    assign status.skip_lookup = oor_next;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.classify)
        begin
            bucket_reg <= bucket_next;
            oor_reg    <= oor_next;
            idx_reg    <= idx_next;
        end
    end

    // Entry table: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (update)
        begin
            entry_mem[idx_reg] <= entry_next;
        end
        if (dp_cmd.lookup)
        begin
            rdata_reg <= entry_mem[idx_reg];
        end
    end

    // Lookup of the valid bit and the bucket totals.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.lookup)
        begin
            rvalid_reg   <= valid_reg[idx_reg];
            total_rd_reg <= total_reg[bucket_reg];
            lone_rd_reg  <= lone_reg[bucket_reg];
        end
    end

    // A never-written entry reads as the empty entry.
    assign entry_eff = rvalid_reg ? rdata_reg : ENTRY_EMPTY;
    assign key       = {req_reg.edge_count, req_reg.vertex_count};

    // Key compares against the stored minimum and maximum.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.compare)
        begin
            lt_min_reg <= key < entry_eff.min_key;
            gt_max_reg <= key > entry_eff.max_key;
        end
    end

    // Updated values for a placed record.
    always_comb
    begin
        entry_next.count   = sat_inc(entry_eff.count);
        entry_next.min_key = lt_min_reg ? key : entry_eff.min_key;
        entry_next.max_key = gt_max_reg ? key : entry_eff.max_key;
        total_next         = sat_inc(total_rd_reg);
        lone_next          = req_reg.layer_is_one ? sat_inc(lone_rd_reg) : lone_rd_reg;
    end

    assign update = dp_cmd.finish && (req_reg.cmd == CMD_RECORD) && !oor_reg;

    // Valid bits, bucket totals and record number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            record_reg <= CNT_W'(1);
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                total_reg[i] <= '0;
                lone_reg[i]  <= '0;
            end
        end
        else if (update)
        begin
            valid_reg[idx_reg]    <= 1'b1;
            record_reg            <= record_reg + 1'b1;
            total_reg[bucket_reg] <= total_next;
            lone_reg[bucket_reg]  <= lone_next;
        end
    end

    // Result item.
    always_comb
    begin
        rsp_next = '0;
        if (req_reg.cmd == CMD_RECORD)
        begin
            if (oor_reg)
            begin
                rsp_next.out_of_range = 1'b1;
            end
            else
            begin
                rsp_next.bucket                 = bucket_reg;
                rsp_next.record_number          = record_reg;
                rsp_next.entry_count            = entry_next.count;
                rsp_next.min_edges              = entry_next.min_key[KEY_W-1:VAL_W];
                rsp_next.min_vertices           = entry_next.min_key[VAL_W-1:0];
                rsp_next.max_edges              = entry_next.max_key[KEY_W-1:VAL_W];
                rsp_next.max_vertices           = entry_next.max_key[VAL_W-1:0];
                rsp_next.bucket_total           = total_next;
                rsp_next.bucket_layer_one_total = lone_next;
            end
        end
        else
        begin
            rsp_next.bucket        = bucket_reg;
            rsp_next.record_number = record_reg - 1'b1;
            if (oor_reg)
            begin
                rsp_next.out_of_range = 1'b1;
                rsp_next.min_edges    = '1;
                rsp_next.min_vertices = '1;
            end
            else
            begin
                rsp_next.entry_count            = entry_eff.count;
                rsp_next.min_edges              = entry_eff.min_key[KEY_W-1:VAL_W];
                rsp_next.min_vertices           = entry_eff.min_key[VAL_W-1:0];
                rsp_next.max_edges              = entry_eff.max_key[KEY_W-1:VAL_W];
                rsp_next.max_vertices           = entry_eff.max_key[VAL_W-1:0];
                rsp_next.bucket_total           = total_rd_reg;
                rsp_next.bucket_layer_one_total = lone_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

[hdl/threshold_bin_statistics.sv]
`timescale 1ns / 1ps

// Histogram of component records over edge-count buckets, with a count and a
// lexicographic (edges, then vertices) minimum and maximum per bucket and
// layer slot, plus per-bucket totals and a running record number. One item
// is in flight at a time: it is classified against all thresholds in use at
// once, then the entry table is read, compared and written back (an item out
// of range skips the read and compare), the result is registered with the
// write-back and offered, and the next item is taken in the cycle after the
// result is. Entries never written read as empty through per-entry valid bits,
// so the block is ready straight out of reset.
module threshold_bin_statistics
    import tbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp
);

    dp_cmd_t    dp_cmd;
    dp_status_t status;

    // Sequencer.
    tbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .dp_cmd    (dp_cmd)
    );

    // Thresholds, tables and result register.
    tbs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .dp_cmd    (dp_cmd),
        .status    (status),
        .rsp       (rsp)
    );

endmodule
